// ===== rtl/mpwc_pkg.sv =====
// Shared types, codes and constants of the multichannel pulse-width capture block.
package mpwc_pkg;

  localparam int CHANNELS_DEF   = 8;
  localparam int STAMP_BITS_DEF = 16;

  localparam int CH_W    = 3;
  localparam int STAMP_W = 16;
  localparam int WIDTH_W = 16;
  localparam int JUMP_W  = 16;
  localparam int MASK_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [JUMP_W-1:0] MAX_JUMP_RST = 16'd2000;
  localparam logic [MASK_W-1:0] ENABLE_RST   = 8'd127;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_JUMP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd1;

  typedef enum logic [2:0] {
    ST_RISE     = 3'd0,
    ST_ACCEPT   = 3'd1,
    ST_WRAP     = 3'd2,
    ST_JUMP     = 3'd3,
    ST_DISABLED = 3'd4
  } status_t;

  // Classification of one event, as the front hands it to the back.
  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic            in_range;
    logic            disabled;
  } ev_tag_t;

endpackage

// ===== rtl/mpwc_front.sv =====
// Front part: accepts capture events, classifies them and queues them for the back part.
module mpwc_front #(
  parameter int CHANNELS   = mpwc_pkg::CHANNELS_DEF,
  parameter int STAMP_BITS = mpwc_pkg::STAMP_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mpwc_pkg::CH_W-1:0]     channel,
  input  logic [mpwc_pkg::STAMP_W-1:0]  stamp,
  input  logic [mpwc_pkg::MASK_W-1:0]   enable_mask,
  output logic                          q_valid,
  output mpwc_pkg::ev_tag_t             q_tag,
  output logic [STAMP_BITS-1:0]         q_stamp,
  input  logic                          q_pop
);

  localparam int QDEPTH = 2;

  mpwc_pkg::ev_tag_t       tag_mem   [QDEPTH];
  logic [STAMP_BITS-1:0]   stamp_mem [QDEPTH];
  logic                    wr_ptr;
  logic                    rd_ptr;
  logic [1:0]              count;
  mpwc_pkg::ev_tag_t       tag_in;
  logic                    push;

  always_comb begin
    tag_in.channel  = channel;
    tag_in.in_range = (32'(channel) < CHANNELS);
    tag_in.disabled = !tag_in.in_range || !enable_mask[channel];
  end

  assign in_stall = (count == 2'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_tag    = tag_mem[rd_ptr];
  assign q_stamp  = stamp_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (!push && q_pop) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      tag_mem[wr_ptr]   <= tag_in;
      stamp_mem[wr_ptr] <= STAMP_BITS'(stamp);
    end
  end

endmodule

// ===== rtl/mpwc_back.sv =====
// Back part: per-channel read-modify-write of phase, rise stamp and width, plus the result register.
module mpwc_back #(
  parameter int CHANNELS   = mpwc_pkg::CHANNELS_DEF,
  parameter int STAMP_BITS = mpwc_pkg::STAMP_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  mpwc_pkg::ev_tag_t             q_tag,
  input  logic [STAMP_BITS-1:0]         q_stamp,
  output logic                          q_pop,
  input  logic [mpwc_pkg::JUMP_W-1:0]   max_jump,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mpwc_pkg::CH_W-1:0]     out_channel,
  output logic [2:0]                    event_status,
  output logic [mpwc_pkg::WIDTH_W-1:0]  width
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CMP_W = (STAMP_BITS > mpwc_pkg::JUMP_W) ? STAMP_BITS : mpwc_pkg::JUMP_W;

  logic                    awaiting_fall [CHANNELS];
  logic [STAMP_BITS-1:0]   rise_stamp    [CHANNELS];
  logic [STAMP_BITS-1:0]   pulse_width   [CHANNELS];

  logic [IDX_W-1:0]        idx;
  logic                    rd_aw;
  logic [STAMP_BITS-1:0]   rd_rise;
  logic [STAMP_BITS-1:0]   rd_pw;
  logic [STAMP_BITS-1:0]   new_w;
  logic [STAMP_BITS-1:0]   diff;
  mpwc_pkg::status_t       status_next;
  logic [STAMP_BITS-1:0]   width_next;
  logic                    upd;
  mpwc_pkg::status_t       status_reg;

  assign q_pop = q_valid && (!out_valid || !out_stall);
  assign idx   = IDX_W'(q_tag.channel);
  assign upd   = q_pop && !q_tag.disabled;

  always_comb begin
    rd_aw   = 1'b0;
    rd_rise = '0;
    rd_pw   = '0;
    if (q_tag.in_range) begin
      rd_aw   = awaiting_fall[idx];
      rd_rise = rise_stamp[idx];
      rd_pw   = pulse_width[idx];
    end
    new_w = q_stamp - rd_rise;
    diff  = (new_w >= rd_pw) ? (new_w - rd_pw) : (rd_pw - new_w);
    width_next = rd_pw;
    if (q_tag.disabled) begin
      status_next = mpwc_pkg::ST_DISABLED;
    end else if (!rd_aw) begin
      status_next = mpwc_pkg::ST_RISE;
    end else if (!(q_stamp > rd_rise)) begin
      status_next = mpwc_pkg::ST_WRAP;
    end else if (CMP_W'(diff) < CMP_W'(max_jump)) begin
      status_next = mpwc_pkg::ST_ACCEPT;
      width_next  = new_w;
    end else begin
      status_next = mpwc_pkg::ST_JUMP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        awaiting_fall[c] <= 1'b0;
        rise_stamp[c]    <= '0;
        pulse_width[c]   <= '0;
      end
    end else if (upd) begin
      awaiting_fall[idx] <= !rd_aw;
      if (!rd_aw) begin
        rise_stamp[idx] <= q_stamp;
      end
      pulse_width[idx] <= width_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_channel <= q_tag.channel;
      status_reg  <= status_next;
      width       <= mpwc_pkg::WIDTH_W'(width_next);
    end
  end

  assign event_status = status_reg;

endmodule

// ===== rtl/multichannel_pulse_width_capture.sv =====
// Top level of the multichannel pulse-width capture block: configuration registers and the two parts.
//
//   channel   direction  handshake             payload
//   in        in         in_valid / in_stall   channel, stamp
//   out       out        out_valid / out_stall out_channel, event_status, width
//   cfg       in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One event per cycle is sustained while out_stall is low. An accepted event is written into the
// queue and, when it is popped, carried through the channel read-modify-write into the result
// register. The per-channel state is read and written back when the event is popped, so events
// of the same channel may follow each other directly. Synchronous reset clears phase, stamps,
// widths, the queue and loads the register reset values. An output stall holds the result and,
// once the two-entry queue fills, raises in_stall. cfg_ready is always high.
module multichannel_pulse_width_capture #(
  parameter int CHANNELS   = mpwc_pkg::CHANNELS_DEF,
  parameter int STAMP_BITS = mpwc_pkg::STAMP_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mpwc_pkg::CH_W-1:0]         channel,
  input  logic [mpwc_pkg::STAMP_W-1:0]      stamp,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mpwc_pkg::CH_W-1:0]         out_channel,
  output logic [2:0]                        event_status,
  output logic [mpwc_pkg::WIDTH_W-1:0]      width,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mpwc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mpwc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [mpwc_pkg::JUMP_W-1:0] max_jump;
  logic [mpwc_pkg::MASK_W-1:0] enable_mask;
  logic                        q_valid;
  logic                        q_pop;
  mpwc_pkg::ev_tag_t           q_tag;
  logic [STAMP_BITS-1:0]       q_stamp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_jump    <= mpwc_pkg::MAX_JUMP_RST;
      enable_mask <= mpwc_pkg::ENABLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mpwc_pkg::REG_MAX_JUMP: max_jump    <= cfg_data;
        mpwc_pkg::REG_ENABLE:   enable_mask <= cfg_data[mpwc_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  mpwc_front #(
    .CHANNELS   (CHANNELS),
    .STAMP_BITS (STAMP_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .channel     (channel),
    .stamp       (stamp),
    .enable_mask (enable_mask),
    .q_valid     (q_valid),
    .q_tag       (q_tag),
    .q_stamp     (q_stamp),
    .q_pop       (q_pop)
  );

  mpwc_back #(
    .CHANNELS   (CHANNELS),
    .STAMP_BITS (STAMP_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_tag        (q_tag),
    .q_stamp      (q_stamp),
    .q_pop        (q_pop),
    .max_jump     (max_jump),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_channel  (out_channel),
    .event_status (event_status),
    .width        (width)
  );

`ifndef SYNTHESIS
  // A full queue always has an event for the back part.
  a_stall_has_work: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_valid)
    else $error("input stalled with an empty queue");

  // An accepted event is queued on the next cycle.
  a_push_queued: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> q_valid)
    else $error("accepted event missing from the queue");

  // Only channels that exist can report anything other than disabled.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_status != mpwc_pkg::ST_DISABLED)) |-> (32'(out_channel) < CHANNELS))
    else $error("non-disabled result for a channel that does not exist");
`endif

endmodule

// ===== test/tb_multichannel_pulse_width_capture.sv =====
// Self-checking testbench for the multichannel pulse-width capture block.
`timescale 1ns / 1ps

module tb_multichannel_pulse_width_capture;

  localparam int NUM_CH        = mpwc_pkg::CHANNELS_DEF;
  localparam int CLK_HALF      = 5;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 195;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logic [mpwc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [mpwc_pkg::CH_W-1:0]    channel;
    mpwc_pkg::status_t            status;
    logic [mpwc_pkg::WIDTH_W-1:0] width;
  } capture_t;

  typedef enum logic {ROW_EVENT, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                      kind;
    logic [mpwc_pkg::CH_W-1:0]      ch;
    logic [mpwc_pkg::STAMP_W-1:0]   data;
    logic [mpwc_pkg::CFG_IDX_W-1:0] index;
    logic                           typed;
    mpwc_pkg::status_t              status;
    logic [mpwc_pkg::WIDTH_W-1:0]   width;
  } row_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [mpwc_pkg::CH_W-1:0]       channel = '0;
  logic [mpwc_pkg::STAMP_W-1:0]    stamp = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [mpwc_pkg::CH_W-1:0]       out_channel;
  logic [2:0]                      event_status;
  logic [mpwc_pkg::WIDTH_W-1:0]    width;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [mpwc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mpwc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Mirror of the per-channel capture state and the two registers.
  logic                         fall_pending [NUM_CH];
  logic [mpwc_pkg::STAMP_W-1:0] rise_at      [NUM_CH];
  logic [mpwc_pkg::WIDTH_W-1:0] width_held   [NUM_CH];
  logic [mpwc_pkg::JUMP_W-1:0]  jump_limit;
  logic [mpwc_pkg::MASK_W-1:0]  enable_bits;

  capture_t    expected_captures[$];
  row_t        directed_rows[$];
  bit          quiet_mode = 1'b0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned events_sent = 0;
  int unsigned writes_done = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  int unsigned status_seen [5];

  multichannel_pulse_width_capture dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .channel(channel), .stamp(stamp),
    .out_valid(out_valid), .out_stall(out_stall), .out_channel(out_channel),
    .event_status(event_status), .width(width),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  function automatic capture_t predict_capture(input logic [mpwc_pkg::CH_W-1:0] ch,
                                               input logic [mpwc_pkg::STAMP_W-1:0] st);
    capture_t                     r;
    logic [mpwc_pkg::WIDTH_W-1:0] fresh;
    logic [mpwc_pkg::WIDTH_W-1:0] diff;
    r.channel = ch;
    if (!enable_bits[ch]) begin
      r.status = mpwc_pkg::ST_DISABLED;
    end else if (!fall_pending[ch]) begin
      rise_at[ch] = st;
      fall_pending[ch] = 1'b1;
      r.status = mpwc_pkg::ST_RISE;
    end else begin
      fall_pending[ch] = 1'b0;
      if (st > rise_at[ch]) begin
        fresh = st - rise_at[ch];
        diff = (fresh >= width_held[ch]) ? fresh - width_held[ch] : width_held[ch] - fresh;
        if (diff < jump_limit) begin
          width_held[ch] = fresh;
          r.status = mpwc_pkg::ST_ACCEPT;
        end else begin
          r.status = mpwc_pkg::ST_JUMP;
        end
      end else begin
        r.status = mpwc_pkg::ST_WRAP;
      end
    end
    r.width = width_held[ch];
    return r;
  endfunction

  function automatic int unsigned idle_draw();
    return quiet_mode ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic void add_event(input logic [mpwc_pkg::CH_W-1:0] ch,
                                    input logic [mpwc_pkg::STAMP_W-1:0] st,
                                    input logic typed,
                                    input mpwc_pkg::status_t status,
                                    input logic [mpwc_pkg::WIDTH_W-1:0] w);
    row_t row;
    row.kind = ROW_EVENT;
    row.ch = ch;
    row.data = st;
    row.index = mpwc_pkg::REG_MAX_JUMP;
    row.typed = typed;
    row.status = status;
    row.width = w;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_write(input logic [mpwc_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [mpwc_pkg::STAMP_W-1:0] value);
    row_t row;
    row.kind = ROW_WRITE;
    row.ch = '0;
    row.data = value;
    row.index = idx;
    row.typed = 1'b0;
    row.status = mpwc_pkg::ST_RISE;
    row.width = '0;
    directed_rows.push_back(row);
  endfunction

  task automatic send_event(input logic [mpwc_pkg::CH_W-1:0] ch,
                            input logic [mpwc_pkg::STAMP_W-1:0] st,
                            input logic typed, input capture_t typed_result);
    int unsigned gap;
    capture_t    predicted;
    gap = idle_draw();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    channel <= ch;
    stamp <= st;
    do @(posedge clk); while (!(in_valid && !in_stall));
    predicted = predict_capture(ch, st);
    expected_captures.push_back(typed ? typed_result : predicted);
    events_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_captures.size() != 0);
  endtask

  // Registers only change while nothing is in flight.
  task automatic write_register(input logic [mpwc_pkg::CFG_IDX_W-1:0] idx,
                                input logic [mpwc_pkg::CFG_DATA_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      mpwc_pkg::REG_MAX_JUMP: jump_limit = value;
      mpwc_pkg::REG_ENABLE:   enable_bits = value[mpwc_pkg::MASK_W-1:0];
      default: ;
    endcase
    writes_done++;
  endtask

  // Mostly well-formed rise/fall pairs whose widths stay near the held width.
  task automatic random_event();
    logic [mpwc_pkg::CH_W-1:0] ch;
    int unsigned               roll;
    int                        span;
    int                        delta;
    int                        target;
    ch = mpwc_pkg::CH_W'($urandom_range(0, NUM_CH - 1));
    for (int tries = 0; tries < 4 && !enable_bits[ch]; tries++)
      ch = mpwc_pkg::CH_W'($urandom_range(0, NUM_CH - 1));
    roll = $urandom_range(0, 99);
    span = (jump_limit < 3000) ? int'(jump_limit) : 3000;
    if (!fall_pending[ch] || !enable_bits[ch]) begin
      target = (roll < 80) ? int'($urandom_range(0, 40000)) : int'($urandom_range(0, 65535));
    end else if (roll < 60) begin
      delta = int'($urandom_range(0, 2 * span)) - span;
      target = int'(rise_at[ch]) + int'(width_held[ch]) + delta;
    end else if (roll < 75) begin
      // Land exactly on the jump limit or one tick inside it.
      delta = int'(jump_limit) - int'(roll[1]);
      if (roll[0]) delta = -delta;
      target = int'(rise_at[ch]) + int'(width_held[ch]) + delta;
    end else if (roll < 85) begin
      target = int'(rise_at[ch]) - int'($urandom_range(0, 3));
    end else begin
      target = int'($urandom_range(0, 65535));
    end
    send_event(ch, target[mpwc_pkg::STAMP_W-1:0], 1'b0, '0);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, expected_captures.size());
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin : result_check
    capture_t    want;
    int unsigned pause;
    if (rst) begin
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      results_seen++;
      if (event_status <= mpwc_pkg::ST_DISABLED) status_seen[event_status]++;
      if (expected_captures.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: channel %0d status %0d width %0d",
                   out_channel, event_status, width);
      end else begin
        want = expected_captures.pop_front();
        if (out_channel !== want.channel || event_status !== want.status ||
            width !== want.width) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result %0d: expected ch %0d status %0d width %0d, %s %0d %s %0d %s %0d",
                     results_seen, want.channel, want.status, want.width,
                     "got ch", out_channel, "status", event_status, "width", width);
        end
      end
      pause = idle_draw();
      out_stall <= (pause != 0);
      stall_left <= pause;
    end else if (stall_left != 0) begin
      out_stall <= (stall_left > 1);
      stall_left <= stall_left - 1;
    end
  end

  initial begin
    capture_t                    typed_result;
    logic [mpwc_pkg::JUMP_W-1:0] phase_jump;
    logic [mpwc_pkg::MASK_W-1:0] phase_mask;
    for (int c = 0; c < NUM_CH; c++) begin
      fall_pending[c] = 1'b0;
      rise_at[c] = '0;
      width_held[c] = '0;
    end
    jump_limit = mpwc_pkg::MAX_JUMP_RST;
    enable_bits = mpwc_pkg::ENABLE_RST;

    // Events: channel, stamp, typed, status, width. Writes: register, data.
    add_event(3'd0, 16'd0,     1'b1, mpwc_pkg::ST_RISE,     16'd0);
    add_event(3'd0, 16'd0,     1'b1, mpwc_pkg::ST_WRAP,     16'd0);
    add_event(3'd7, 16'd65535, 1'b1, mpwc_pkg::ST_DISABLED, 16'd0);
    add_event(3'd1, 16'd100,   1'b1, mpwc_pkg::ST_RISE,     16'd0);
    add_event(3'd1, 16'd2099,  1'b1, mpwc_pkg::ST_ACCEPT,   16'd1999);
    add_event(3'd2, 16'd0,     1'b1, mpwc_pkg::ST_RISE,     16'd0);
    add_event(3'd2, 16'd2000,  1'b1, mpwc_pkg::ST_JUMP,     16'd0);
    add_event(3'd3, 16'd65535, 1'b1, mpwc_pkg::ST_RISE,     16'd0);
    add_event(3'd3, 16'd0,     1'b1, mpwc_pkg::ST_WRAP,     16'd0);
    add_event(3'd6, 16'd30000, 1'b1, mpwc_pkg::ST_RISE,     16'd0);
    add_event(3'd6, 16'd31234, 1'b0, mpwc_pkg::ST_RISE,     16'd0);
    add_write(mpwc_pkg::REG_MAX_JUMP, 16'd0);
    add_event(3'd4, 16'd10,    1'b1, mpwc_pkg::ST_RISE,     16'd0);
    add_event(3'd4, 16'd11,    1'b1, mpwc_pkg::ST_JUMP,     16'd0);
    add_write(mpwc_pkg::REG_MAX_JUMP, 16'd65535);
    add_write(mpwc_pkg::REG_ENABLE, 16'd255);
    add_event(3'd7, 16'd0,     1'b1, mpwc_pkg::ST_RISE,     16'd0);
    add_event(3'd7, 16'd65535, 1'b1, mpwc_pkg::ST_JUMP,     16'd0);
    add_event(3'd7, 16'd1,     1'b1, mpwc_pkg::ST_RISE,     16'd0);
    add_event(3'd7, 16'd65534, 1'b1, mpwc_pkg::ST_ACCEPT,   16'd65533);
    add_write(mpwc_pkg::REG_ENABLE, 16'd0);
    add_event(3'd5, 16'd1234,  1'b1, mpwc_pkg::ST_DISABLED, 16'd0);
    add_event(3'd1, 16'd77,    1'b1, mpwc_pkg::ST_DISABLED, 16'd1999);
    add_write(REG_SPARE, 16'hFFFF);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        write_register(directed_rows[i].index, directed_rows[i].data);
      end else begin
        typed_result.channel = directed_rows[i].ch;
        typed_result.status = directed_rows[i].status;
        typed_result.width = directed_rows[i].width;
        send_event(directed_rows[i].ch, directed_rows[i].data, directed_rows[i].typed,
                   typed_result);
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      quiet_mode = 1'b0;
      case (phase)
        0: begin
          phase_jump = mpwc_pkg::MAX_JUMP_RST;
          phase_mask = mpwc_pkg::ENABLE_RST;
        end
        1: begin phase_jump = 16'd0;        phase_mask = 8'hFF; end
        2: begin phase_jump = 16'hFFFF;     phase_mask = 8'hFF; end
        3: begin phase_jump = 16'd1;        phase_mask = 8'hFF; quiet_mode = 1'b1; end
        4: begin phase_jump = 16'd300;      phase_mask = 8'hA5; end
        5: begin
          phase_jump = mpwc_pkg::JUMP_W'($urandom_range(0, 65535));
          phase_mask = mpwc_pkg::MASK_W'($urandom_range(0, 255));
        end
        6: begin phase_jump = 16'd5000;     phase_mask = 8'hFF; quiet_mode = 1'b1; end
        default: begin
          phase_jump = mpwc_pkg::JUMP_W'($urandom_range(1, 4000));
          phase_mask = 8'hFF;
        end
      endcase
      write_register(mpwc_pkg::REG_MAX_JUMP, phase_jump);
      // Upper data bits are junk for the mask register and must be dropped.
      write_register(mpwc_pkg::REG_ENABLE, {8'($urandom), phase_mask});
      if (phase == 5) write_register(REG_SPARE, 16'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_event();
        if ($urandom_range(0, 149) == 0) drain_results();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_captures.size() != 0) begin
      $display("%0d expected results never arrived.", expected_captures.size());
      mismatches += expected_captures.size();
    end

    $display("Sent %0d capture events and %0d register writes; checked %0d results.",
             events_sent, writes_done, results_seen);
    $display("Rises %0d, accepted %0d, wrap rejects %0d, jump rejects %0d, disabled %0d.",
             status_seen[mpwc_pkg::ST_RISE], status_seen[mpwc_pkg::ST_ACCEPT],
             status_seen[mpwc_pkg::ST_WRAP], status_seen[mpwc_pkg::ST_JUMP],
             status_seen[mpwc_pkg::ST_DISABLED]);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
